### rtl/mstff_pkg.sv
// ----------------------------------------------------------------------------
// mstff_pkg
// Shared types and constants for the max segment tree first-fit unit.
// ----------------------------------------------------------------------------
package mstff_pkg;

	localparam int LEAVES_DEF     = 1024;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_READ  = 3'd1;
	localparam logic [2:0] OP_RANGE = 3'd2;
	localparam logic [2:0] OP_FIND  = 3'd3;
	localparam logic [2:0] OP_TAKE  = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [9:0]  position;
		logic [9:0]  position_end;
		logic [31:0] amount;
	} cmd_t;

	typedef struct packed {
		logic        found;
		logic [9:0]  result_index;
		logic [31:0] result_value;
	} rsp_t;

endpackage

### rtl/max_segment_tree_first_fit_unit.sv
// ----------------------------------------------------------------------------
// max_segment_tree_first_fit_unit
// Max tree over the leaf values with write, read, range max, find first and
// take first fit, run as a read-modify-write sequencer over one node memory.
// ----------------------------------------------------------------------------
//  channel   | signals            | beat taken when
//  ----------+--------------------+----------------------------------------
//  command   | start, busy, cmd   | start high and busy low at the edge
//  response  | done, rsp          | done high, one cycle, cannot be held off
//
// The node memory has a single registered read port, so write, find and
// take walk the tree one level per cycle; range max alternates its left
// and right states at each level.
// Out-of-range, empty and unknown commands answer in the next cycle.
// After reset busy stays high while every node is zeroed.
// One command at a time; the response is registered and leaves on its own.
module max_segment_tree_first_fit_unit #(
	parameter int LEAVES     = mstff_pkg::LEAVES_DEF,
	parameter int VALUE_BITS = mstff_pkg::VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mstff_pkg::cmd_t   cmd,
	output logic              done,
	output mstff_pkg::rsp_t   rsp
);

	localparam int LB = $clog2(LEAVES);
	localparam int P  = 1 << LB;
	localparam int AW = LB + 1;
	localparam int LW = LB + 2;
	localparam int VB = VALUE_BITS;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_RDLF  = 8'b0000_0010,
		S_FROOT = 8'b0000_0100,
		S_FDN   = 8'b0000_1000,
		S_FLEAF = 8'b0001_0000,
		S_UP    = 8'b0010_0000,
		S_RL    = 8'b0100_0000,
		S_RR    = 8'b1000_0000
	} state_t;

	state_t          state_q, state_d;
	logic [AW-1:0]   k_q, k_d;
	logic [VB-1:0]   v_q, v_d;
	logic [LW-1:0]   l_q, l_d;
	logic [AW-1:0]   r_q, r_d;
	logic [VB-1:0]   best_q, best_d;
	logic            acc_q, acc_d;
	logic            take_q, take_d;
	logic [VB-1:0]   amt_q, amt_d;
	logic            done_q, done_d;
	mstff_pkg::rsp_t rsp_q, rsp_d;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [VB-1:0]   wdata;
	logic [AW-1:0]   raddr;
	logic [VB-1:0]   rdata;
	logic            clr_busy;

	logic            accept;
	logic [VB-1:0]   amt_in;
	logic [31:0]     pos32;
	logic [31:0]     end_cl;
	logic            pos_ok;
	logic [AW-1:0]   leaf_addr;
	logic [VB-1:0]   best_eff;
	logic [AW-1:0]   kn;
	logic [AW-1:0]   parent;
	logic [VB-1:0]   pv;
	logic [VB-1:0]   nv;
	logic [AW-1:0]   r_n;

	mstff_tree_mem #(
		.ADDR_BITS(AW),
		.DATA_BITS(VB)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr    (raddr),
		.rdata    (rdata),
		.clr_busy (clr_busy)
	);

	assign busy   = (state_q != S_IDLE) || clr_busy;
	assign accept = start && !busy;

	assign amt_in    = VB'(cmd.amount);
	assign pos32     = 32'(cmd.position);
	assign pos_ok    = pos32 < 32'(LEAVES);
	assign end_cl    = (32'(cmd.position_end) >= 32'(LEAVES)) ? 32'(LEAVES - 1)
	                                                         : 32'(cmd.position_end);
	assign leaf_addr = AW'(P) + AW'(cmd.position);
	// pending node read from the previous cycle folds into the running max
	assign best_eff  = (acc_q && (rdata > best_q)) ? rdata : best_q;
	assign kn        = (rdata >= amt_q) ? {k_q[AW-2:0], 1'b0} : {k_q[AW-2:0], 1'b1};
	assign parent    = {1'b0, k_q[AW-1:1]};
	assign pv        = (rdata > v_q) ? rdata : v_q;
	assign nv        = rdata - amt_q;
	assign r_n       = r_q[0] ? r_q : (r_q - AW'(1));

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		v_d     = v_q;
		l_d     = l_q;
		r_d     = r_q;
		best_d  = best_q;
		acc_d   = 1'b0;
		take_d  = take_q;
		amt_d   = amt_q;
		done_d  = 1'b0;
		rsp_d   = rsp_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		raddr   = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					rsp_d.found        = 1'b1;
					rsp_d.result_index = '0;
					rsp_d.result_value = '0;
					case (cmd.op)
						mstff_pkg::OP_WRITE: begin
							if (pos_ok) begin
								we      = 1'b1;
								waddr   = leaf_addr;
								wdata   = amt_in;
								raddr   = leaf_addr ^ AW'(1);
								k_d     = leaf_addr;
								v_d     = amt_in;
								state_d = S_UP;
							end else begin
								done_d = 1'b1;
							end
						end
						mstff_pkg::OP_READ: begin
							if (pos_ok) begin
								raddr   = leaf_addr;
								state_d = S_RDLF;
							end else begin
								done_d = 1'b1;
							end
						end
						mstff_pkg::OP_RANGE: begin
							if (pos32 <= end_cl) begin
								l_d     = LW'(P) + LW'(cmd.position);
								r_d     = AW'(P) + AW'(end_cl);
								best_d  = '0;
								state_d = S_RL;
							end else begin
								done_d = 1'b1;
							end
						end
						mstff_pkg::OP_FIND, mstff_pkg::OP_TAKE: begin
							raddr   = AW'(1);
							take_d  = (cmd.op == mstff_pkg::OP_TAKE);
							amt_d   = amt_in;
							state_d = S_FROOT;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_RDLF: begin
				rsp_d.result_value = 32'(rdata);
				done_d             = 1'b1;
				state_d            = S_IDLE;
			end
			S_FROOT: begin
				if (rdata < amt_q) begin
					rsp_d.found = 1'b0;
					done_d      = 1'b1;
					state_d     = S_IDLE;
				end else begin
					raddr   = AW'(2);
					k_d     = AW'(1);
					state_d = S_FDN;
				end
			end
			S_FDN: begin
				// rdata is the left child; right is taken only when left falls short
				k_d = kn;
				if (kn[AW-1]) begin
					raddr   = kn;
					state_d = S_FLEAF;
				end else begin
					raddr = {kn[AW-2:0], 1'b0};
				end
			end
			S_FLEAF: begin
				rsp_d.result_index = 10'(k_q[LB-1:0]);
				rsp_d.result_value = 32'(rdata);
				if (take_q) begin
					rsp_d.result_value = 32'(nv);
					we      = 1'b1;
					waddr   = k_q;
					wdata   = nv;
					raddr   = k_q ^ AW'(1);
					v_d     = nv;
					state_d = S_UP;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_UP: begin
				// rdata is the sibling of k_q, read while k_q was written
				we    = 1'b1;
				waddr = parent;
				wdata = pv;
				raddr = parent ^ AW'(1);
				k_d   = parent;
				v_d   = pv;
				if (parent == AW'(1)) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RL: begin
				if (l_q > {1'b0, r_q}) begin
					rsp_d.result_value = 32'(best_eff);
					done_d             = 1'b1;
					state_d            = S_IDLE;
				end else begin
					best_d = best_eff;
					if (l_q[0]) begin
						raddr = AW'(l_q);
						acc_d = 1'b1;
						l_d   = l_q + LW'(1);
					end
					state_d = S_RR;
				end
			end
			S_RR: begin
				best_d = best_eff;
				if (!r_q[0]) begin
					raddr = r_q;
					acc_d = 1'b1;
				end
				l_d     = l_q >> 1;
				r_d     = r_n >> 1;
				state_d = S_RL;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			acc_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			acc_q   <= acc_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q    <= k_d;
		v_q    <= v_d;
		l_q    <= l_d;
		r_q    <= r_d;
		best_q <= best_d;
		take_q <= take_d;
		amt_q  <= amt_d;
		rsp_q  <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### rtl/mstff_tree_mem.sv
// ----------------------------------------------------------------------------
// mstff_tree_mem
// Node storage of the max tree: one write port, one registered read port,
// and a zeroing sweep over every node after reset.
// ----------------------------------------------------------------------------
module mstff_tree_mem #(
	parameter int ADDR_BITS = 11,
	parameter int DATA_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata,
	output logic                 clr_busy
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [DATA_BITS-1:0] mem_q [DEPTH];
	logic [DATA_BITS-1:0] rdata_q;
	logic [ADDR_BITS-1:0] clr_cnt_q;
	logic                 clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_BITS'(1);
			if (clr_cnt_q == {ADDR_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_cnt_q] <= '0;
		end else if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata    = rdata_q;
	assign clr_busy = clr_busy_q;

endmodule

### rtl/mstff_checker.sv
// ----------------------------------------------------------------------------
// mstff_checker
// Port-level checks of the command/response sequencing of the unit.
// ----------------------------------------------------------------------------
module mstff_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input mstff_pkg::rsp_t rsp
);

	// a taken command either answers at once or keeps the unit busy
	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("command beat taken with no progress");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response beat while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done && !start |=> !done)
		else $error("response beat repeated");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.found |-> rsp.result_index == 10'd0 && rsp.result_value == 32'd0)
		else $error("miss response carries data");

endmodule

bind max_segment_tree_first_fit_unit mstff_checker u_mstff_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
